>>> hdl/itaf_pkg.sv
// Shared types, character codes and a helper function of the integer to ASCII formatter.
package itaf_pkg;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONVERT,
        ST_SKIP,
        ST_EMIT
    } state_t;

    localparam int unsigned DIGIT_COUNT = 10;
    localparam int unsigned DIGIT_BITS  = 4 * DIGIT_COUNT;
    localparam int unsigned HEX_DIGITS  = 8;

    localparam logic [6:0] CHAR_ZERO  = 7'h30;
    localparam logic [6:0] CHAR_MINUS = 7'h2D;
    localparam logic [6:0] CHAR_X     = 7'h78;
    localparam logic [6:0] CHAR_A     = 7'h61;

    localparam logic [1:0] PRE_NONE  = 2'd0;
    localparam logic [1:0] PRE_ONE   = 2'd1;
    localparam logic [1:0] PRE_TWO   = 2'd2;

    // ASCII code of one digit or nibble, lower case for 0xA to 0xF
    function automatic logic [6:0] nibble_char(input logic [3:0] nib);
        logic [6:0] code;
        if (nib >= 4'hA)
        begin
            code = CHAR_A + {3'b000, nib - 4'hA};
        end
        else
        begin
            code = CHAR_ZERO + {3'b000, nib};
        end
        return code;
    endfunction

endpackage

>>> hdl/integer_to_ascii_formatter_unit.sv
// Top level of the integer to ASCII formatter: signed decimal or 0x hex text, one char a beat.

// Formats one signed 32-bit value per request as ASCII text, most significant character
// first, one character per output beat, with tlast on the final character. s_tuser = 0
// selects signed decimal (leading '-' for negatives, no leading zeros, the most negative
// value prints as -2147483648); s_tuser = 1 selects "0x" followed by lower-case hex
// digits with leading zeros dropped and at least one digit. No terminator is sent.
// One request is handled at a time and s_tready stays low until the final character has
// been taken. Steps per request: the idle state takes the request, then for decimal a
// shift-and-add-3 binary to BCD loop shifts in one magnitude bit at a time, then leading
// zero digits are dropped, then the digits are sent, after a minus sign for a negative
// value. Hex skips the BCD loop: leading zero nibbles are dropped, then "0x" and the
// nibbles are sent. Output stalls hold the sending state. The 40-bit digit shift register
// is shared by both modes; its per-digit add-3 adjust serves the BCD loop.
module integer_to_ascii_formatter_unit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] value
    input  logic        s_tuser,   // [0] mode (0 decimal, 1 hex)
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [6:0] char_code, [7] zero
    output logic        m_tlast    // last character of the text
);
    import itaf_pkg::*;

    state_t                  state_reg, state_next;
    logic [DIGIT_BITS-1:0]   dig_reg, dig_next;     // BCD digits or hex nibbles, top first
    logic [31:0]             bin_reg, bin_next;     // magnitude being shifted into BCD
    logic [4:0]              bit_reg, bit_next;     // BCD loop bits left minus one
    logic [3:0]              cnt_reg, cnt_next;     // digits left to send
    logic [1:0]              pre_reg, pre_next;     // prefix characters left to send
    logic                    hex_reg, hex_next;

    logic                    in_fire;
    logic                    out_fire;
    logic                    top_zero;
    logic                    is_last;
    logic [6:0]              char_code;
    logic [DIGIT_BITS-1:0]   dig_adj;
    logic [31:0]             mag;

    assign in_fire  = s_tvalid && s_tready;
    assign out_fire = m_tvalid && m_tready;
    assign top_zero = (dig_reg[DIGIT_BITS-1 -: 4] == 4'h0) && (cnt_reg > 4'd1);
    assign is_last  = (pre_reg == PRE_NONE) && (cnt_reg == 4'd1);

    // Two's complement magnitude; the most negative value maps to 0x80000000 unsigned
    assign mag = s_tdata[31] ? (32'd0 - s_tdata) : s_tdata;

    // Add 3 to every BCD digit of 5 or more before the next shift
    always_comb
    begin
        for (int d = 0; d < DIGIT_COUNT; d++)
        begin
            if (dig_reg[4*d +: 4] >= 4'd5)
            begin
                dig_adj[4*d +: 4] = dig_reg[4*d +: 4] + 4'd3;
            end
            else
            begin
                dig_adj[4*d +: 4] = dig_reg[4*d +: 4];
            end
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = s_tuser ? ST_SKIP : ST_CONVERT;
                end
            end
            ST_CONVERT:
            begin
                if (bit_reg == 5'd0)
                begin
                    state_next = ST_SKIP;
                end
            end
            ST_SKIP:
            begin
                if (!top_zero)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_fire && is_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath next values
    always_comb
    begin
        dig_next = dig_reg;
        bin_next = bin_reg;
        bit_next = bit_reg;
        cnt_next = cnt_reg;
        pre_next = pre_reg;
        hex_next = hex_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    hex_next = s_tuser;
                    bin_next = mag;
                    bit_next = 5'd31;
                    if (s_tuser)
                    begin
                        // load nibbles at the top of the digit register
                        dig_next = {s_tdata, {(DIGIT_BITS-32){1'b0}}};
                        cnt_next = 4'(HEX_DIGITS);
                        pre_next = PRE_TWO;
                    end
                    else
                    begin
                        dig_next = '0;
                        cnt_next = 4'(DIGIT_COUNT);
                        pre_next = s_tdata[31] ? PRE_ONE : PRE_NONE;
                    end
                end
            end
            ST_CONVERT:
            begin
                // adjust, then shift the next magnitude bit into the BCD digits
                dig_next = {dig_adj[DIGIT_BITS-2:0], bin_reg[31]};
                bin_next = {bin_reg[30:0], 1'b0};
                bit_next = bit_reg - 5'd1;
            end
            ST_SKIP:
            begin
                // drop one leading zero digit a cycle, keep at least one
                if (top_zero)
                begin
                    dig_next = {dig_reg[DIGIT_BITS-5:0], 4'h0};
                    cnt_next = cnt_reg - 4'd1;
                end
            end
            ST_EMIT:
            begin
                if (out_fire)
                begin
                    if (pre_reg != PRE_NONE)
                    begin
                        pre_next = pre_reg - 2'd1;
                    end
                    else
                    begin
                        dig_next = {dig_reg[DIGIT_BITS-5:0], 4'h0};
                        cnt_next = cnt_reg - 4'd1;
                    end
                end
            end
            default:
            begin
                dig_next = dig_reg;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        if (pre_reg == PRE_NONE)
        begin
            char_code = nibble_char(dig_reg[DIGIT_BITS-1 -: 4]);
        end
        else if (hex_reg)
        begin
            char_code = (pre_reg == PRE_TWO) ? CHAR_ZERO : CHAR_X;
        end
        else
        begin
            char_code = CHAR_MINUS;
        end
        s_tready = (state_reg == ST_IDLE);
        m_tvalid = (state_reg == ST_EMIT);
        m_tdata  = {1'b0, char_code};
        m_tlast  = is_last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            bit_reg   <= '0;
            cnt_reg   <= '0;
            pre_reg   <= PRE_NONE;
            hex_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            bit_reg   <= bit_next;
            cnt_reg   <= cnt_next;
            pre_reg   <= pre_next;
            hex_reg   <= hex_next;
        end
    end

    // Payload registers, no reset
    always_ff @(posedge clk)
    begin
        dig_reg <= dig_next;
        bin_reg <= bin_next;
    end

`ifndef SYNTH
    // Never accept a request while characters of the previous one are pending
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid))
        else $error("input ready while output valid");

    // An accepted request always leaves idle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> !s_tready)
        else $error("still ready after accepting a request");

    // Taking the last character returns to idle
    a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_fire && m_tlast) |=> s_tready)
        else $error("not idle after final character");

    // A digit always remains while sending
    a_digit_left: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (cnt_reg != 4'd0))
        else $error("sending with no digit left");
`endif

endmodule
